>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands, clocked on a rising edge and
// disabled while reset is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffd_pkg.sv
// ---------------------------------------------------------------------------
// ffd_pkg
// types, codes and defaults shared by the file directory allocator
// ---------------------------------------------------------------------------
package ffd_pkg;

    localparam int ENTRIES_DEF       = 64;
    localparam int SECTOR_BYTES_DEF  = 4096;
    localparam int TOTAL_SECTORS_DEF = 4096;

    localparam int MODE_W   = 2;
    localparam int BYTES_W  = 25;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 25'd1048576;
    localparam logic [BYTES_W-1:0] BYTES_MAX       = 25'h1FFFFFF;

    localparam logic [MODE_W-1:0] MODE_SAVE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_READY     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_INVALID   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } ffd_status_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BYTES_W-1:0] file_size;
        logic               file_format;
        logic [INDEX_W-1:0] entry_index;
    } ffd_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_code;
        logic [SLOT_W-1:0]   slot;
        logic [START_W-1:0]  first_sector;
        logic [COUNT_W-1:0]  file_count;
        logic [BYTES_W-1:0]  used_bytes;
    } ffd_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        scan_start;
        logic        scan_run;
        logic        save_commit;
        logic        del_read;
        logic        del_commit;
        logic        fmt_clear;
        logic        set_code;
        ffd_status_t code;
        logic        emit;
    } ffd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic              not_ready;
        logic [MODE_W-1:0] mode;
        logic              size_bad;
        logic              idx_bad;
        logic              idx_valid;
        logic              scan_done;
        logic              found;
        logic              fits;
        logic              out_free;
    } ffd_stat_t;

endpackage

>>> rtl/ffd_req_if.sv
// ---------------------------------------------------------------------------
// ffd_req_if
// request channel: valid/ready handshake carrying one request word
// ---------------------------------------------------------------------------
interface ffd_req_if;
    logic             valid;
    logic             ready;
    ffd_pkg::ffd_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ffd_rsp_if.sv
// ---------------------------------------------------------------------------
// ffd_rsp_if
// result channel: valid/ready handshake carrying one result word
// ---------------------------------------------------------------------------
interface ffd_rsp_if;
    logic             valid;
    logic             ready;
    ffd_pkg::ffd_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ffd_ram.sv
// ---------------------------------------------------------------------------
// ffd_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ffd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/ffd_ctrl.sv
// ---------------------------------------------------------------------------
// ffd_ctrl
// request sequencer: decodes a request and steps the datapath through
// scan, check, delete, format and result hand-off
// ---------------------------------------------------------------------------
module ffd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ffd_pkg::ffd_stat_t st,
    output ffd_pkg::ffd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_CHECK,
        S_DEL_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ffd_pkg::ST_OK;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next   = S_FINISH;
                cmd.set_code = 1'b1;
                if (st.not_ready)
                begin
                    cmd.code = ffd_pkg::ST_NOT_READY;
                end
                else
                begin
                    case (st.mode)
                        ffd_pkg::MODE_SAVE:
                        begin
                            if (st.size_bad)
                            begin
                                cmd.code = ffd_pkg::ST_INVALID;
                            end
                            else
                            begin
                                cmd.set_code   = 1'b0;
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        ffd_pkg::MODE_DELETE:
                        begin
                            if (st.idx_bad)
                            begin
                                cmd.code = ffd_pkg::ST_INVALID;
                            end
                            else if (!st.idx_valid)
                            begin
                                cmd.code = ffd_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                cmd.set_code = 1'b0;
                                cmd.del_read = 1'b1;
                                state_next   = S_DEL_WAIT;
                            end
                        end
                        ffd_pkg::MODE_FORMAT:
                        begin
                            cmd.fmt_clear = 1'b1;
                            cmd.code      = ffd_pkg::ST_OK;
                        end
                        default:
                        begin
                            cmd.code = ffd_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.set_code = 1'b1;
                if (st.found && st.fits)
                begin
                    cmd.save_commit = 1'b1;
                    cmd.code        = ffd_pkg::ST_OK;
                end
                else
                begin
                    cmd.code = ffd_pkg::ST_FULL;
                end
                state_next = S_FINISH;
            end
            S_DEL_WAIT:
            begin
                cmd.del_commit = 1'b1;
                cmd.set_code   = 1'b1;
                cmd.code       = ffd_pkg::ST_OK;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/ffd_dpath.sv
// ---------------------------------------------------------------------------
// ffd_dpath
// directory datapath: config registers, valid bits, entry ram, free-slot
// and end-sector scan, sector count, totals and result register
// ---------------------------------------------------------------------------
module ffd_dpath #(
    parameter int ENTRIES       = ffd_pkg::ENTRIES_DEF,
    parameter int SECTOR_BYTES  = ffd_pkg::SECTOR_BYTES_DEF,
    parameter int TOTAL_SECTORS = ffd_pkg::TOTAL_SECTORS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ffd_pkg::BYTES_W-1:0]         cfg_data,
    input  ffd_pkg::ffd_req_t                   req_data,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output ffd_pkg::ffd_rsp_t                   rsp_data,
    input  ffd_pkg::ffd_cmd_t                   cmd,
    output ffd_pkg::ffd_stat_t                  st
);

    localparam int BYTES_W  = ffd_pkg::BYTES_W;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int SCNT_W   = IDX_W + 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int SEC_W    = $clog2(TOTAL_SECTORS + 1);
    localparam int SUM_W    = BYTES_W + $clog2(ENTRIES);
    localparam int DIV_W    = BYTES_W + 1;
    localparam int SB_SHIFT = $clog2(SECTOR_BYTES);
    localparam int FIT_W    = DIV_W + 1;
    localparam int WORD_W   = 1 + BYTES_W + SEC_W;

    // config
    logic                  ready_cfg_reg;
    logic [BYTES_W-1:0]    max_bytes_reg;

    // latched request
    logic [ffd_pkg::MODE_W-1:0] mode_reg;
    logic [BYTES_W-1:0]    size_reg;
    logic                  fmt_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  idx_bad_reg;

    // directory state
    logic [ENTRIES-1:0]    valid_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SUM_W-1:0]      sum_reg;

    // scan
    logic [SCNT_W-1:0]     scan_cnt_reg;
    logic                  pend_reg;
    logic                  pend_valid_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      free_reg;
    logic [SEC_W-1:0]      max_reg;

    // rounded-up sector count of the requested size
    logic [DIV_W-1:0]      need_reg;

    ffd_pkg::ffd_status_t  code_reg;
    logic                  save_ok_reg;
    logic                  rsp_valid_reg;
    ffd_pkg::ffd_rsp_t     rsp_data_reg;

    logic                  issue;
    logic [IDX_W-1:0]      scan_addr;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     ram_wdata;
    logic [SEC_W-1:0]      rd_end;
    logic [BYTES_W-1:0]    rd_bytes;
    logic [DIV_W-1:0]      round_up;
    logic [FIT_W-1:0]      end_sum;
    logic [SEC_W-1:0]      new_end;
    logic [BYTES_W-1:0]    bytes_sat;

    assign scan_addr = scan_cnt_reg[IDX_W-1:0];
    assign issue     = cmd.scan_run && (scan_cnt_reg != SCNT_W'(ENTRIES));
    assign ram_re    = issue || cmd.del_read;
    assign ram_raddr = issue ? scan_addr : idx_reg;
    assign rd_end    = ram_rdata[SEC_W-1:0];
    assign rd_bytes  = ram_rdata[SEC_W +: BYTES_W];

    // sector size is a power of two, so the count is a shift
    assign round_up = DIV_W'(size_reg) + DIV_W'(SECTOR_BYTES - 1);

    assign end_sum   = FIT_W'(max_reg) + FIT_W'(need_reg);
    assign new_end   = end_sum[SEC_W-1:0];
    assign ram_wdata = {fmt_reg, size_reg, new_end};

    assign bytes_sat = (sum_reg > SUM_W'(ffd_pkg::BYTES_MAX)) ? ffd_pkg::BYTES_MAX
                                                              : sum_reg[BYTES_W-1:0];

    always_comb
    begin
        st.not_ready = !ready_cfg_reg;
        st.mode      = mode_reg;
        st.size_bad  = (size_reg == '0) || (size_reg > max_bytes_reg);
        st.idx_bad   = idx_bad_reg;
        st.idx_valid = valid_reg[idx_reg];
        st.scan_done = (scan_cnt_reg == SCNT_W'(ENTRIES)) && !pend_reg;
        st.found     = found_reg;
        st.fits      = end_sum <= FIT_W'(TOTAL_SECTORS);
        st.out_free  = !rsp_valid_reg || rsp_ready;
    end

    ffd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (cmd.save_commit),
        .waddr (free_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_cfg_reg <= 1'b0;
            max_bytes_reg <= ffd_pkg::MAX_BYTES_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            save_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ffd_pkg::CFG_READY:     ready_cfg_reg <= cfg_data[0];
                    ffd_pkg::CFG_MAX_BYTES: max_bytes_reg <= cfg_data;
                    default:                ;
                endcase
            end

            if (cmd.scan_start)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
            end
            else if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + SCNT_W'(1);
                if (!found_reg && !valid_reg[scan_addr])
                begin
                    found_reg <= 1'b1;
                end
            end
            pend_reg <= issue;

            if (cmd.load)
            begin
                save_ok_reg <= 1'b0;
            end

            if (cmd.save_commit)
            begin
                valid_reg[free_reg] <= 1'b1;
                count_reg           <= count_reg + CNT_W'(1);
                sum_reg             <= sum_reg + SUM_W'(size_reg);
                save_ok_reg         <= 1'b1;
            end
            else if (cmd.del_commit)
            begin
                valid_reg[idx_reg] <= 1'b0;
                count_reg          <= count_reg - CNT_W'(1);
                sum_reg            <= sum_reg - SUM_W'(rd_bytes);
            end
            else if (cmd.fmt_clear)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
            end

            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= req_data.mode;
            size_reg    <= req_data.file_size;
            fmt_reg     <= req_data.file_format;
            idx_reg     <= IDX_W'(req_data.entry_index);
            idx_bad_reg <= 32'(req_data.entry_index) >= ENTRIES;
        end

        if (cmd.scan_start)
        begin
            max_reg  <= SEC_W'(1);
            need_reg <= round_up >> SB_SHIFT;
        end
        else if (pend_reg && pend_valid_reg && (rd_end > max_reg))
        begin
            max_reg <= rd_end;
        end
        pend_valid_reg <= valid_reg[scan_addr];
        if (issue && !found_reg && !valid_reg[scan_addr])
        begin
            free_reg <= scan_addr;
        end

        if (cmd.set_code)
        begin
            code_reg <= cmd.code;
        end

        if (cmd.emit)
        begin
            rsp_data_reg.status_code  <= code_reg;
            rsp_data_reg.slot         <= save_ok_reg ? ffd_pkg::SLOT_W'(free_reg) : '0;
            rsp_data_reg.first_sector <= save_ok_reg ? ffd_pkg::START_W'(max_reg) : '0;
            if (code_reg == ffd_pkg::ST_NOT_READY)
            begin
                rsp_data_reg.file_count <= '0;
                rsp_data_reg.used_bytes <= '0;
            end
            else
            begin
                rsp_data_reg.file_count <= ffd_pkg::COUNT_W'(count_reg);
                rsp_data_reg.used_bytes <= bytes_sat;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

>>> rtl/flash_file_directory_allocator.sv
// ---------------------------------------------------------------------------
// flash_file_directory_allocator
// file directory allocator for a sector-addressed flash
// ---------------------------------------------------------------------------
// One request word is taken at a time. A save scans the directory,
// reading one directory entry per cycle from the entry ram's single read
// port, before its result word can be taken. The result sits in an
// output register, so the next request is accepted while an earlier
// result waits to be taken. The directory reads all-empty right after
// reset with no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module flash_file_directory_allocator #(
    parameter int ENTRIES       = ffd_pkg::ENTRIES_DEF,
    parameter int SECTOR_BYTES  = ffd_pkg::SECTOR_BYTES_DEF,
    parameter int TOTAL_SECTORS = ffd_pkg::TOTAL_SECTORS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffd_pkg::BYTES_W-1:0]   cfg_data,
    ffd_req_if.sink                       req,
    ffd_rsp_if.source                     rsp
);

    ffd_pkg::ffd_cmd_t  cmd;
    ffd_pkg::ffd_stat_t st;
    logic               req_ready;
    logic               rsp_valid;
    ffd_pkg::ffd_rsp_t  rsp_data;

    ffd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ffd_dpath #(
        .ENTRIES       (ENTRIES),
        .SECTOR_BYTES  (SECTOR_BYTES),
        .TOTAL_SECTORS (TOTAL_SECTORS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .st        (st)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

    // one request in flight
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req.valid && req_ready, !req_ready, "request accepted while busy")
    // not-ready answers carry no totals
    `ASSERT_IMPLY(a_not_ready_zero, clk, rst_n, rsp_valid && (rsp_data.status_code == ffd_pkg::ST_NOT_READY), (rsp_data.file_count == '0) && (rsp_data.used_bytes == '0), "not-ready result with totals")
    // only a good save reports a slot or start sector
    `ASSERT_IMPLY(a_fail_no_slot, clk, rst_n, rsp_valid && (rsp_data.status_code != ffd_pkg::ST_OK), (rsp_data.slot == '0) && (rsp_data.first_sector == '0), "failed request reports a slot")
    // bytes in use need at least one file
    `ASSERT_IMPLY(a_bytes_need_file, clk, rst_n, rsp_valid && (rsp_data.used_bytes != '0), rsp_data.file_count != '0, "bytes in use with no files")

endmodule
